FILE: rtl/dph_pkg.sv
// Shared types, codes and constants for the depth-hold PID controller.
// Used by dph_cfg, dph_ctrl, dph_dp and depth_pid_hold_controller; no dependencies.
package dph_pkg;

    // Operation codes carried by an input word
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_START   = 2'd1,
        OP_PREEMPT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Goal status codes carried by a result word
    typedef enum logic [1:0] {
        GS_IDLE      = 2'd0,
        GS_RUNNING   = 2'd1,
        GS_SUCCEEDED = 2'd2,
        GS_PREEMPTED = 2'd3
    } goal_status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TARGET_DEPTH    = 3'd0,
        CFG_HOLD_TICKS      = 3'd1,
        CFG_GAINS_STABILIZE = 3'd2,
        CFG_GAINS_UPWARD    = 3'd3,
        CFG_BAND_STABILIZE  = 3'd4,
        CFG_BAND_ASCEND     = 3'd5,
        CFG_MAX_PWM         = 3'd6,
        CFG_UNUSED          = 3'd7
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_CLAMP,
        ST_RECIP,
        ST_FIX,
        ST_COMMIT
    } fsm_state_t;

    // Datapath work step for the current cycle
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_CALC,
        STEP_MUL_P,
        STEP_MUL_I,
        STEP_MUL_D,
        STEP_ACC,
        STEP_CLAMP,
        STEP_RECIP,
        STEP_FIX
    } step_t;

    typedef struct packed {
        logic  load;     // capture the accepted input word
        logic  commit;   // update state and load the result word
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic op_tick;   // latched word is a control tick
    } status_t;

    typedef struct packed {
        logic signed [15:0] target_depth;
        logic [15:0]        hold_ticks;
        logic [47:0]        gains_stabilize;
        logic [47:0]        gains_upward;
        logic [7:0]         band_stabilize;
        logic [7:0]         band_ascend;
        logic [7:0]         max_pwm;
    } cfg_t;

    // Gain set switch point on hold_ticks
    localparam logic [15:0] STAB_THRESHOLD = 16'd10000;

    // Arithmetic widths
    localparam int PROD_W = 48;   // 16 x 32 signed product
    localparam int ACC_W  = 50;   // sum of three products
    localparam int MAG_W  = 26;   // magnitude after the +-1000.0 clamp
    localparam int Y_W    = 18;   // magnitude * 255 / 2^16
    localparam int Q_W    = 8;    // PWM magnitude

    // Output clamp: 1000 in Q.16
    localparam logic signed [ACC_W-1:0] OUT_LIM     = 50'sd65536000;
    localparam logic signed [ACC_W-1:0] OUT_LIM_NEG = -50'sd65536000;

    localparam int unsigned PWM_FULL    = 255;
    localparam int unsigned DIV_CONST   = 1000;
    // floor(2^20 / 1000); estimate is low by at most one
    localparam int unsigned RECIP_MUL   = 1048;
    localparam int          RECIP_SHIFT = 20;

endpackage

FILE: rtl/dph_cfg.sv
// Configuration register file for the depth-hold PID controller.
// Depends on dph_pkg for the register index codes and the cfg_t bundle.
module dph_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dph_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dph_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dph_pkg::cfg_t                     cfg
);
    import dph_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TARGET_DEPTH:    cfg_next.target_depth    = cfg_data[15:0];
                CFG_HOLD_TICKS:      cfg_next.hold_ticks      = cfg_data[15:0];
                CFG_GAINS_STABILIZE: cfg_next.gains_stabilize = cfg_data[47:0];
                CFG_GAINS_UPWARD:    cfg_next.gains_upward    = cfg_data[47:0];
                CFG_BAND_STABILIZE:  cfg_next.band_stabilize  = cfg_data[7:0];
                CFG_BAND_ASCEND:     cfg_next.band_ascend     = cfg_data[7:0];
                CFG_MAX_PWM:         cfg_next.max_pwm         = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_depth    <= '0;
            cfg_reg.hold_ticks      <= '0;
            cfg_reg.gains_stabilize <= '0;
            cfg_reg.gains_upward    <= '0;
            cfg_reg.band_stabilize  <= '0;
            cfg_reg.band_ascend     <= '0;
            cfg_reg.max_pwm         <= 8'd255;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/dph_ctrl.sv
// Sequencing state machine for the depth-hold PID controller.
// Depends on dph_pkg; drives dph_dp through cmd_t and owns the result valid flag.
module dph_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  dph_pkg::status_t  status,
    output dph_pkg::cmd_t     cmd
);
    import dph_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    // Result slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_CALC;
            ST_CALC:   state_next = status.op_tick ? ST_MUL_P : ST_COMMIT;
            ST_MUL_P:  state_next = ST_MUL_I;
            ST_MUL_I:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_ACC;
            ST_ACC:    state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_RECIP;
            ST_RECIP:  state_next = ST_FIX;
            ST_FIX:    state_next = ST_COMMIT;
            ST_COMMIT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        cmd.step   = STEP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CALC:   cmd.step = STEP_CALC;
            ST_MUL_P:  cmd.step = STEP_MUL_P;
            ST_MUL_I:  cmd.step = STEP_MUL_I;
            ST_MUL_D:  cmd.step = STEP_MUL_D;
            ST_ACC:    cmd.step = STEP_ACC;
            ST_CLAMP:  cmd.step = STEP_CLAMP;
            ST_RECIP:  cmd.step = STEP_RECIP;
            ST_FIX:    cmd.step = STEP_FIX;
            ST_COMMIT: cmd.commit = out_free;
            default: ;
        endcase
    end

    // Result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // A result is only loaded into a free slot
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an undelivered word");

    // An accepted word always starts the calc step next cycle
    a_accept_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CALC))
        else $error("accepted word not followed by calc step");

    // Valid rises only after a commit
    a_valid_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.commit))
        else $error("result valid raised without commit");

endmodule

FILE: rtl/dph_dp.sv
// Datapath of the depth-hold PID controller: error, integral, shared multiplier,
// clamp and PWM scaling, goal state and the result register. Depends on dph_pkg.
module dph_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dph_pkg::cmd_t        cmd,
    output dph_pkg::status_t     status,
    input  dph_pkg::cfg_t        cfg,
    input  logic [1:0]           s_operation,
    input  logic signed [15:0]   s_depth_sample,
    output logic signed [8:0]    m_pwm_drive,
    output logic signed [16:0]   m_depth_remaining,
    output logic [1:0]           m_goal_status
);
    import dph_pkg::*;

    // Latched input word
    op_t                      op_reg;
    logic signed [15:0]       sample_reg;

    // Per-tick working registers
    logic signed [16:0]       err_reg;
    logic signed [16:0]       deriv_reg;
    logic signed [31:0]       int_new_reg;
    logic [47:0]              gains_reg;
    logic [7:0]               band_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     neg_reg;
    logic [Y_W-1:0]           y_reg;
    logic [Q_W-1:0]           q0_reg;
    logic [Q_W-1:0]           q_reg;

    // Controller state
    logic signed [31:0]       integral_reg, integral_next;
    logic signed [15:0]       last_depth_reg, last_depth_next;
    logic                     have_last_reg, have_last_next;
    logic [15:0]              count_reg, count_next;
    logic                     active_reg, active_next;

    // Result word
    logic signed [8:0]        out_pwm_reg, out_pwm_next;
    logic signed [16:0]       out_rem_reg, out_rem_next;
    goal_status_t             out_status_reg, out_status_next;

    // Calc step signals
    logic signed [16:0]       err_c;
    logic signed [15:0]       prev_c;
    logic signed [16:0]       deriv_c;
    logic signed [32:0]       int_sum;
    logic signed [31:0]       int_sat;
    logic                     stab_c;

    // Multiplier operands
    logic signed [15:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // Clamp and scale signals
    logic signed [ACC_W-1:0]  clamped;
    logic [ACC_W-1:0]         mag_full;
    logic [MAG_W-1:0]         mag;
    logic [33:0]              scaled;
    logic [28:0]              recip_prod;
    logic [Y_W-1:0]           q0_scaled;
    logic [Y_W-1:0]           rem_c;

    // Commit signals
    logic [Q_W-1:0]           mag_lim;
    logic                     in_band;
    logic [15:0]              count_inc;
    logic signed [8:0]        pwm_val;

    assign status.op_tick = (op_reg == OP_TICK);

    // Error, derivative and saturated integral candidate
    always_comb begin
        err_c   = {cfg.target_depth[15], cfg.target_depth} - {sample_reg[15], sample_reg};
        prev_c  = have_last_reg ? last_depth_reg : sample_reg;
        deriv_c = {sample_reg[15], sample_reg} - {prev_c[15], prev_c};
        int_sum = {integral_reg[31], integral_reg} + {{16{err_c[16]}}, err_c};
        if (int_sum[32] != int_sum[31]) begin
            int_sat = int_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            int_sat = int_sum[31:0];
        end
        stab_c = cfg.hold_ticks > STAB_THRESHOLD;
    end

    // Shared multiplier: kp*e, ki*I, kd*D in turn
    always_comb begin
        case (cmd.step)
            STEP_MUL_I: begin
                mul_a = gains_reg[31:16];
                mul_b = int_new_reg;
            end
            STEP_MUL_D: begin
                mul_a = gains_reg[47:32];
                mul_b = {{15{deriv_reg[16]}}, deriv_reg};
            end
            default: begin
                mul_a = gains_reg[15:0];
                mul_b = {{15{err_reg[16]}}, err_reg};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Clamp to +-1000.0, magnitude times 255 over 2^16
    always_comb begin
        if (acc_reg > OUT_LIM) begin
            clamped = OUT_LIM;
        end else if (acc_reg < OUT_LIM_NEG) begin
            clamped = OUT_LIM_NEG;
        end else begin
            clamped = acc_reg;
        end
        mag_full = acc_reg[ACC_W-1] ? ACC_W'(-clamped) : ACC_W'(clamped);
        mag      = mag_full[MAG_W-1:0];
        scaled   = 34'(mag) * 34'(PWM_FULL);
    end

    // Divide by 1000: reciprocal estimate then one correction
    always_comb begin
        recip_prod = 29'(y_reg) * 29'(RECIP_MUL);
        q0_scaled  = Y_W'(q0_reg) * Y_W'(DIV_CONST);
        rem_c      = y_reg - q0_scaled;
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= op_t'(s_operation);
            sample_reg <= s_depth_sample;
        end
        case (cmd.step)
            STEP_CALC: begin
                err_reg     <= err_c;
                deriv_reg   <= deriv_c;
                int_new_reg <= int_sat;
                gains_reg   <= stab_c ? cfg.gains_stabilize : cfg.gains_upward;
                band_reg    <= stab_c ? cfg.band_stabilize : cfg.band_ascend;
            end
            STEP_MUL_P: prod_reg <= mul_p;
            STEP_MUL_I: begin
                prod_reg <= mul_p;
                acc_reg  <= ACC_W'(prod_reg);
            end
            STEP_MUL_D: begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + ACC_W'(prod_reg);
            end
            STEP_ACC:   acc_reg <= acc_reg + ACC_W'(prod_reg);
            STEP_CLAMP: begin
                neg_reg <= acc_reg[ACC_W-1];
                y_reg   <= scaled[33:16];
            end
            STEP_RECIP: q0_reg <= recip_prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
            STEP_FIX:   q_reg  <= q0_reg + Q_W'(rem_c >= Y_W'(DIV_CONST));
            default: ;
        endcase
    end

    // Max PWM clamp and dead band
    always_comb begin
        mag_lim   = (q_reg > cfg.max_pwm) ? cfg.max_pwm : q_reg;
        in_band   = mag_lim <= band_reg;
        pwm_val   = neg_reg ? 9'sd0 - $signed({1'b0, mag_lim}) : $signed({1'b0, mag_lim});
        count_inc = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
    end

    // Goal state and result word
    always_comb begin
        integral_next   = integral_reg;
        last_depth_next = last_depth_reg;
        have_last_next  = have_last_reg;
        count_next      = count_reg;
        active_next     = active_reg;
        out_pwm_next    = '0;
        out_rem_next    = '0;
        out_status_next = active_reg ? GS_RUNNING : GS_IDLE;
        if (cmd.commit) begin
            case (op_reg)
                OP_START: begin
                    integral_next   = '0;
                    count_next      = '0;
                    active_next     = (cfg.hold_ticks != 16'd0);
                    out_status_next = (cfg.hold_ticks != 16'd0) ? GS_RUNNING : GS_IDLE;
                end
                OP_PREEMPT: begin
                    active_next     = 1'b0;
                    out_status_next = GS_PREEMPTED;
                end
                OP_TICK: begin
                    last_depth_next = sample_reg;
                    have_last_next  = 1'b1;
                    out_rem_next    = err_reg;
                    if (active_reg) begin
                        integral_next = int_new_reg;
                        if (in_band) begin
                            count_next = count_inc;
                            if (count_inc >= cfg.hold_ticks) begin
                                out_status_next = GS_SUCCEEDED;
                                active_next     = 1'b0;
                            end
                        end else begin
                            count_next   = '0;
                            out_pwm_next = pwm_val;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg   <= '0;
            last_depth_reg <= '0;
            have_last_reg  <= 1'b0;
            count_reg      <= '0;
            active_reg     <= 1'b0;
        end else begin
            integral_reg   <= integral_next;
            last_depth_reg <= last_depth_next;
            have_last_reg  <= have_last_next;
            count_reg      <= count_next;
            active_reg     <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_pwm_reg    <= out_pwm_next;
            out_rem_reg    <= out_rem_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_pwm_drive       = out_pwm_reg;
    assign m_depth_remaining = out_rem_reg;
    assign m_goal_status     = out_status_reg;

    // A success always drives the thruster to zero
    a_success_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (out_status_reg != GS_SUCCEEDED || out_pwm_reg == 9'sd0))
        else $error("succeeded word with nonzero pwm");

    // Start clears the integral and the hold count
    a_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && op_reg == OP_START) |=> (integral_reg == 32'sd0 && count_reg == 16'd0))
        else $error("start did not clear integral and hold count");

endmodule

FILE: rtl/depth_pid_hold_controller.sv
// Top level of the depth-hold PID controller.
// Instantiates dph_cfg, dph_ctrl and dph_dp; depends on dph_pkg.
//
// Each input word is a control tick, a goal start, a preempt or the unused code and gives
// exactly one result word (PWM, remaining depth error, goal status). The block works on
// one word at a time and takes no new word until the last has reached the result register.
// A tick passes through the calc step, the single shared 16x32 multiplier that forms the
// proportional, integral and derivative products in turn, the accumulate step, the clamp,
// the 255/1000 scaling (reciprocal multiply with one correction) and the commit; start,
// preempt and the unused code go from the calc step straight to the commit.
// The result sits in an output register, so the next word is accepted and worked on
// while the previous result waits; it then holds at commit until the slot frees.
// Configuration writes are always taken, and are meant to happen only while no word
// is in flight.
module depth_pid_hold_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_operation,
    input  logic signed [15:0]                s_depth_sample,
    // Result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [8:0]                 m_pwm_drive,
    output logic signed [16:0]                m_depth_remaining,
    output logic [1:0]                        m_goal_status,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dph_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dph_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dph_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // Register file
    dph_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer
    dph_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and goal state
    dph_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg               (cfg),
        .s_operation       (s_operation),
        .s_depth_sample    (s_depth_sample),
        .m_pwm_drive       (m_pwm_drive),
        .m_depth_remaining (m_depth_remaining),
        .m_goal_status     (m_goal_status)
    );

endmodule

FILE: verif/depth_pid_hold_controller_test.sv
// Self-checking testbench for depth_pid_hold_controller: directed, random and
// back-to-back runs, checked word by word against a scoreboard predictor.
// Depends on dph_pkg and the depth_pid_hold_controller RTL.
`timescale 1ns / 100ps

module depth_pid_hold_controller_test;

    import dph_pkg::*;

    localparam longint OUT_SPAN     = 64'sd65536000;      // 1000.0 in Q.16
    localparam longint PWM_SCALE    = 64'sd255;
    localparam longint INTEG_MAX    = 64'sd2147483647;
    localparam longint INTEG_MIN    = -64'sd2147483648;
    localparam int     STAB_LEVEL   = 10000;
    localparam int     COUNT_MAX    = 65535;
    localparam int     MAX_REPORTS  = 10;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     PHASES       = 9;
    localparam int     PHASE_WORDS  = 100;
    localparam int     QUIET_TICKS  = 20;      // ticks per run in the no-idle part

    // Expected result word
    typedef struct packed {
        logic signed [8:0]  pwm;
        logic signed [16:0] remaining;
        goal_status_t       status;
    } drive_word_t;

    // Predictor of the regulator plus the queue of results it owes
    class pid_scoreboard;
        logic signed [15:0] tgt;
        logic [15:0]        hold;
        logic [47:0]        gains_stab;
        logic [47:0]        gains_up;
        logic [7:0]         band_stab;
        logic [7:0]         band_up;
        logic [7:0]         pwm_cap;

        longint             integ;
        logic signed [15:0] prev_depth;
        bit                 have_prev;
        int                 in_band;
        bit                 goal_on;

        drive_word_t        owed_words[$];
        int                 errors;
        int                 results_seen;

        function new();
            tgt        = '0;
            hold       = '0;
            gains_stab = '0;
            gains_up   = '0;
            band_stab  = '0;
            band_up    = '0;
            pwm_cap    = 8'd255;
            integ      = 0;
            prev_depth = '0;
            have_prev  = 1'b0;
            in_band    = 0;
            goal_on    = 1'b0;
            errors     = 0;
            results_seen = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [47:0] data);
            case (idx)
                CFG_TARGET_DEPTH:    tgt        = data[15:0];
                CFG_HOLD_TICKS:      hold       = data[15:0];
                CFG_GAINS_STABILIZE: gains_stab = data;
                CFG_GAINS_UPWARD:    gains_up   = data;
                CFG_BAND_STABILIZE:  band_stab  = data[7:0];
                CFG_BAND_ASCEND:     band_up    = data[7:0];
                CFG_MAX_PWM:         pwm_cap    = data[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] %s", $time, msg);
        endfunction

        // Work out the result word caused by an accepted input word
        function void take_word(op_t op, logic signed [15:0] sample);
            longint      err, deriv, acc, pwm, band, cap, kp, ki, kd;
            logic [47:0] g;
            bit          stab;
            drive_word_t w;

            w.pwm       = '0;
            w.remaining = '0;
            w.status    = GS_IDLE;
            case (op)
                OP_START: begin
                    integ   = 0;
                    in_band = 0;
                    goal_on = (hold != 16'd0);
                    w.status = goal_on ? GS_RUNNING : GS_IDLE;
                end
                OP_PREEMPT: begin
                    goal_on  = 1'b0;
                    w.status = GS_PREEMPTED;
                end
                OP_NONE: w.status = goal_on ? GS_RUNNING : GS_IDLE;
                default: begin
                    err   = longint'(tgt) - longint'(sample);
                    deriv = have_prev ? longint'(sample) - longint'(prev_depth) : 0;
                    prev_depth  = sample;
                    have_prev   = 1'b1;
                    w.remaining = err[16:0];
                    if (goal_on) begin
                        stab = (hold > STAB_LEVEL);
                        g    = stab ? gains_stab : gains_up;
                        band = stab ? band_stab : band_up;
                        cap  = pwm_cap;
                        kp   = longint'($signed(g[15:0]));
                        ki   = longint'($signed(g[31:16]));
                        kd   = longint'($signed(g[47:32]));

                        // saturating integral of the raw error
                        integ = integ + err;
                        if (integ > INTEG_MAX) integ = INTEG_MAX;
                        if (integ < INTEG_MIN) integ = INTEG_MIN;

                        acc = kp * err + ki * integ + kd * deriv;
                        if (acc > OUT_SPAN)  acc = OUT_SPAN;
                        if (acc < -OUT_SPAN) acc = -OUT_SPAN;
                        pwm = (acc * PWM_SCALE) / OUT_SPAN;   // truncates toward zero
                        if (pwm > cap)  pwm = cap;
                        if (pwm < -cap) pwm = -cap;

                        w.status = GS_RUNNING;
                        if (pwm <= band && pwm >= -band) begin
                            pwm = 0;
                            if (in_band < COUNT_MAX)
                                in_band++;
                            if (in_band >= hold) begin
                                w.status = GS_SUCCEEDED;
                                goal_on  = 1'b0;
                            end
                        end else begin
                            in_band = 0;
                        end
                        w.pwm = pwm[8:0];
                    end
                end
            endcase
            owed_words.push_back(w);
        endfunction

        // Compare an accepted result word with the oldest expectation
        function void check_word(logic signed [8:0] pwm, logic signed [16:0] rem,
                                 logic [1:0] st);
            drive_word_t w;

            results_seen++;
            if (owed_words.size() == 0) begin
                flag($sformatf("result %0d with nothing expected: pwm %0d rem %0d st %0d",
                               results_seen, pwm, rem, st));
                return;
            end
            w = owed_words.pop_front();
            if (w.pwm !== pwm || w.remaining !== rem || w.status !== st)
                flag($sformatf({"result %0d mismatch: pwm exp %0d got %0d, ",
                                "remaining exp %0d got %0d, status exp %0d got %0d"},
                               results_seen, w.pwm, pwm, w.remaining, rem,
                               w.status, st));
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_operation;
    logic signed [15:0]       s_depth_sample;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [8:0]        m_pwm_drive;
    logic signed [16:0]       m_depth_remaining;
    logic [1:0]               m_goal_status;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    pid_scoreboard      sb;
    bit                 quiet = 1'b0;          // no idling on either side
    bit                 hold_off_req = 1'b0;   // ask the receiver for a long stall
    logic signed [15:0] cur_target = '0;

    depth_pid_hold_controller dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_depth_sample    (s_depth_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pwm_drive       (m_pwm_drive),
        .m_depth_remaining (m_depth_remaining),
        .m_goal_status     (m_goal_status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Handshake monitor feeding the scoreboard
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (m_valid && m_ready)
                sb.check_word(m_pwm_drive, m_depth_remaining, m_goal_status);
            if (s_valid && s_ready)
                sb.take_word(op_t'(s_operation), s_depth_sample);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("** depth_pid_hold_controller: FAILED **");
        $finish;
    end

    // Offer one input word, wait for acceptance, then maybe idle
    task automatic send_word(input op_t op, input logic signed [15:0] sample);
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_depth_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic cfg_put(input cfg_index_t idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write the whole register set back to back
    task automatic program_regs(input logic [15:0] target, input logic [15:0] hold,
                                input logic [47:0] gs, input logic [47:0] gu,
                                input logic [7:0] bs, input logic [7:0] bu,
                                input logic [7:0] cap);
        cfg_put(CFG_TARGET_DEPTH, {32'd0, target});
        cfg_put(CFG_HOLD_TICKS, {32'd0, hold});
        cfg_put(CFG_GAINS_STABILIZE, gs);
        cfg_put(CFG_GAINS_UPWARD, gu);
        cfg_put(CFG_BAND_STABILIZE, {40'd0, bs});
        cfg_put(CFG_BAND_ASCEND, {40'd0, bu});
        cfg_put(CFG_MAX_PWM, {40'd0, cap});
        cfg_put(CFG_UNUSED, 48'({$urandom, $urandom}));   // unmapped, must change nothing
        cfg_valid  <= 1'b0;
        cur_target  = target;
    endtask

    // Stop offering words and wait until every owed result is back
    task automatic drain_block();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 128)) - 64);
        endcase
    endfunction

    function automatic logic [7:0] rand_band();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 30));
        endcase
    endfunction

    function automatic logic [7:0] rand_cap();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(1, 254));
        endcase
    endfunction

    function automatic logic [15:0] rand_hold();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd10000;
            2:       return 16'd10001;
            3:       return 16'd65535;
            4:       return 16'($urandom_range(10002, 65535));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] rand_target();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly samples near the target so goals can settle
    function automatic logic [15:0] pick_sample();
        int spread;
        spread = ($urandom_range(0, 3) == 0) ? 4000 : 12;
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return cur_target + 16'(int'($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    // Goal-shaped random traffic: starts, runs of ticks, some preempts and noise
    task automatic run_words(input int count);
        op_t         op;
        int unsigned r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (!sb.goal_on && r < 35)
                op = OP_START;
            else if (r < 3)
                op = OP_NONE;
            else if (r < 7)
                op = OP_PREEMPT;
            else if (r < 9)
                op = OP_START;
            else
                op = OP_TICK;
            send_word(op, pick_sample());
        end
    endtask

    initial begin
        sb = new();
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_operation    <= OP_TICK;
        s_depth_sample <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_TARGET_DEPTH;
        cfg_data       <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first sample, extremes, every operation, idle cases, hold reached
        program_regs(16'h0100, 16'd3, {16'h0040, 16'h0008, 16'h0080},
                     {16'h0100, 16'h0010, 16'h0200}, 8'd4, 8'd6, 8'd200);
        send_word(OP_START, 16'h0000);
        send_word(OP_TICK, 16'h8000);
        send_word(OP_TICK, 16'h7FFF);
        send_word(OP_NONE, 16'h1234);
        send_word(OP_PREEMPT, 16'h0000);
        send_word(OP_TICK, 16'h0100);
        send_word(OP_NONE, 16'h0000);
        send_word(OP_PREEMPT, 16'hFFFF);
        send_word(OP_START, 16'h0000);
        repeat (3) send_word(OP_TICK, 16'h0100);
        send_word(OP_TICK, 16'h0000);
        drain_block();

        // start with a zero hold count never opens a goal
        program_regs(16'h0100, 16'd0, {16'h0040, 16'h0008, 16'h0080},
                     {16'h0100, 16'h0010, 16'h0200}, 8'd4, 8'd6, 8'd200);
        send_word(OP_START, 16'h0000);
        send_word(OP_TICK, 16'h0123);
        drain_block();

        // stabilize set, then lower the hold count while the goal runs
        program_regs(16'h0100, 16'd20000, {16'h0040, 16'h0008, 16'h0080},
                     {16'h0100, 16'h0010, 16'h0200}, 8'd4, 8'd6, 8'd200);
        send_word(OP_START, 16'h0000);
        repeat (3) send_word(OP_TICK, 16'h0100);
        drain_block();
        program_regs(16'h0100, 16'd2, {16'h0040, 16'h0008, 16'h0080},
                     {16'h0100, 16'h0010, 16'h0200}, 8'd4, 8'd6, 8'd200);
        send_word(OP_TICK, 16'h0100);
        send_word(OP_TICK, 16'h0000);
        drain_block();

        // Random phases, each with its own register set
        for (int p = 0; p < PHASES; p++) begin
            if (p == 1)
                program_regs(16'h7FFF, 16'd65535, {3{16'h7FFF}}, {3{16'h7FFF}},
                             8'd255, 8'd255, 8'd255);
            else if (p == 2)
                program_regs(16'h8000, 16'd0, {3{16'h8000}}, {3{16'h8000}},
                             8'd0, 8'd0, 8'd0);
            else
                program_regs(rand_target(), rand_hold(),
                             {rand_gain(), rand_gain(), rand_gain()},
                             {rand_gain(), rand_gain(), rand_gain()},
                             rand_band(), rand_band(), rand_cap());
            if (p == 4) begin
                // receiver stalls long while words keep coming
                run_words(5);
                hold_off_req = 1'b1;
                run_words(PHASE_WORDS - 5);
            end else begin
                run_words(PHASE_WORDS);
            end
            drain_block();
        end

        // Last part, no idling: largest errors of both signs, words back to back
        quiet = 1'b1;
        program_regs(16'h7FFF, 16'd5, {16'h0040, 16'h0008, 16'h0080},
                     {16'h0000, 16'h0001, 16'h0100}, 8'd0, 8'd0, 8'd255);
        send_word(OP_START, 16'h0000);
        repeat (QUIET_TICKS) send_word(OP_TICK, 16'h8000);
        drain_block();
        program_regs(16'h8000, 16'd5, {16'h0040, 16'h0008, 16'h0080},
                     {16'h0000, 16'h0001, 16'h0100}, 8'd0, 8'd0, 8'd255);
        send_word(OP_START, 16'h0000);
        repeat (QUIET_TICKS) send_word(OP_TICK, 16'h7FFF);
        drain_block();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** depth_pid_hold_controller: PASSED **");
        else
            $display("** depth_pid_hold_controller: FAILED **");
        $finish;
    end

endmodule
